// ===== rtl/dtsp_pkg.sv =====
`default_nettype none
package dtsp_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 1024;
	localparam int unsigned TABLE_SIZE_DEF   = 256;
	localparam int unsigned PERIOD_W         = 20;
	localparam int unsigned TOTAL_W          = 32;

	localparam logic [7:0]          MIDPOINT          = 8'd128;
	localparam logic [PERIOD_W-1:0] TONE_PERIOD_RST   = 20'd8;
	localparam logic [PERIOD_W-1:0] STREAM_PERIOD_RST = 20'd125;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_START = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_PLAY_MODE      = 2'd0,
		REG_TONE_PERIOD    = 2'd1,
		REG_STREAM_PERIOD  = 2'd2,
		REG_OUTPUT_CHANNEL = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_DIRECT = 2'd0,
		SRC_MEM    = 2'd1,
		SRC_HELD   = 2'd2
	} val_src_t;

	typedef struct packed {
		logic                play_mode;
		logic [PERIOD_W-1:0] tone_period;
		logic [PERIOD_W-1:0] stream_period;
		logic                output_channel;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [7:0]         value;
		val_src_t           src;
		logic               chan;
		logic               under;
		logic               empty;
		logic [TOTAL_W-1:0] total;
	} s1_t;

	// restoring shift-subtract quotient, used at elaboration only
	function automatic longint unsigned udiv64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin(pi/2 * r / t) in Q30, Taylor series, truncating arithmetic
	function automatic longint unsigned quarter_sine(input int unsigned r, input int unsigned t);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned div;
		if (r == 0) begin
			return 64'd0;
		end
		if (r >= t) begin
			return ONE_Q30;
		end
		x    = udiv64(HALF_PI_Q30 * 64'(r), 64'(t));
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 12; n++) begin
			div  = 64'((2 * n) * (2 * n + 1));
			term = udiv64((term * x2) >> 30, div);
			if ((n & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return longint'(sum);
	endfunction

	// floor(127.5 * (1 + sin(2*pi*i/t))), evaluated at elaboration only
	function automatic logic [7:0] sine_entry(input int unsigned i, input int unsigned t);
		int unsigned     q;
		int unsigned     quad;
		int unsigned     r;
		int unsigned     f;
		longint unsigned s;
		longint unsigned v;
		q    = 4 * i;
		quad = 32'(udiv64(64'(q), 64'(t)));
		r    = q - quad * t;
		f    = quad[0] ? t - r : r;
		s    = quarter_sine(f, t);
		if (quad < 2) begin
			v = (64'd255 * ONE_Q30 + 64'd255 * s) >> 31;
		end else begin
			v = (64'd255 * ONE_Q30 - 64'd255 * s) >> 31;
		end
		return v[7:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dtsp_sbuf.sv =====
`default_nettype none
module dtsp_sbuf
	import dtsp_pkg::*;
#(
	parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dtsp_sine_rom.sv =====
`default_nettype none
module dtsp_sine_rom
	import dtsp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int unsigned AW         = $clog2(TABLE_SIZE)
) (
	input  wire logic [AW-1:0] addr,
	output logic      [7:0]    data
);

	logic [7:0] rom [TABLE_SIZE];

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		localparam logic [7:0] ENTRY = sine_entry(g, TABLE_SIZE);
		assign rom[g] = ENTRY;
	end

	assign data = rom[addr];

endmodule
`default_nettype wire

// ===== rtl/dtsp_ctrl.sv =====
`default_nettype none
module dtsp_ctrl
	import dtsp_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned TABLE_SIZE   = TABLE_SIZE_DEF,
	parameter int unsigned BAW          = $clog2(BUFFER_DEPTH),
	parameter int unsigned TAW          = $clog2(TABLE_SIZE)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfg_t           cfg,
	input  wire logic           acc,
	input  wire logic [1:0]     cmd,
	input  wire logic           adv,
	output logic      [TAW-1:0] rom_addr,
	input  wire logic [7:0]     rom_data,
	output logic                mem_we,
	output logic      [BAW-1:0] mem_waddr,
	output logic                mem_re,
	output logic      [BAW-1:0] mem_raddr,
	output s1_t                 s1
);

	logic [BAW-1:0]      rp_q, wp_q, rp_inc, wp_inc;
	logic [TAW-1:0]      tp_q, tp_inc;
	logic [PERIOD_W-1:0] tick_q, tick_inc, period;
	logic [TOTAL_W-1:0]  total_q;
	logic                started_q;
	logic                fire;
	logic                buf_nonempty;
	logic                emit;
	s1_t                 s1_d;

	assign rp_inc   = (rp_q == BAW'(BUFFER_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign wp_inc   = (wp_q == BAW'(BUFFER_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign tp_inc   = (tp_q == TAW'(TABLE_SIZE - 1)) ? '0 : tp_q + 1'b1;
	assign tick_inc = tick_q + 1'b1;

	always_comb begin
		period = cfg.play_mode ? cfg.stream_period : cfg.tone_period;
		if (period == '0) begin
			period = PERIOD_W'(1);
		end
	end

	assign fire         = started_q && (tick_inc >= period);
	assign buf_nonempty = (rp_q != wp_q);
	assign rom_addr     = tp_q;
	assign mem_waddr    = wp_q;
	assign mem_raddr    = rp_q;
	assign mem_we       = acc && (cmd == CMD_PUSH) && started_q && cfg.play_mode;
	assign mem_re       = acc && (cmd == CMD_TICK) && fire && cfg.play_mode && buf_nonempty;
	assign emit         = acc && ((cmd == CMD_START) || ((cmd == CMD_TICK) && fire));

	// result payload, loaded with the issuing transaction
	always_comb begin
		s1_d.valid = emit;
		s1_d.chan  = cfg.output_channel;
		s1_d.under = 1'b0;
		s1_d.total = total_q;
		s1_d.src   = SRC_DIRECT;
		s1_d.value = MIDPOINT;
		s1_d.empty = cfg.play_mode;
		if (cmd == CMD_TICK) begin
			if (!cfg.play_mode) begin
				s1_d.value = rom_data;
				s1_d.empty = 1'b0;
			end else if (buf_nonempty) begin
				s1_d.src   = SRC_MEM;
				s1_d.empty = (rp_inc == wp_q);
			end else begin
				s1_d.src   = SRC_HELD;
				s1_d.under = 1'b1;
				s1_d.empty = 1'b1;
				s1_d.total = total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			tp_q      <= '0;
			tick_q    <= '0;
			total_q   <= '0;
			started_q <= 1'b0;
			s1        <= '0;
		end else begin
			if (acc || adv) begin
				s1 <= s1_d;
			end
			if (acc) begin
				case (cmd)
					CMD_START: begin
						rp_q      <= '0;
						wp_q      <= '0;
						tp_q      <= '0;
						tick_q    <= '0;
						started_q <= 1'b1;
					end
					CMD_PUSH: begin
						if (mem_we) begin
							wp_q <= wp_inc;
						end
					end
					CMD_TICK: begin
						if (started_q) begin
							if (!fire) begin
								tick_q <= tick_inc;
							end else begin
								tick_q <= '0;
								if (!cfg.play_mode) begin
									tp_q <= tp_inc;
								end else if (buf_nonempty) begin
									rp_q <= rp_inc;
								end else begin
									total_q <= total_q + 1'b1;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dac_tone_and_stream_player.sv =====
// Pipeline: an accepted input transaction is loaded into the s1 stage at the accepting
// edge, then into the output register that presents its result on m_*.
// Throughput: one transaction per clock unless m_tready stalls the output; the sample buffer is a
// single-port-read, single-port-write RAM read at most once per emitting tick and written
// at most once per push. Reset (arst_n low): pointers, tick count, underrun count and start
// flag clear, held sample returns to 128, registers return to 0, 8, 125, 0.
`default_nettype none
module dac_tone_and_stream_player
	import dtsp_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned TABLE_SIZE   = TABLE_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] sample
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,   // [7:0] dac_value, [8] underrun, [9] buffer_empty,
	                                    // [41:10] underrun_total, [47:42] zero
	output logic      [0:0]  m_tuser,   // [0] dac_channel
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	localparam int unsigned BAW = $clog2(BUFFER_DEPTH);
	localparam int unsigned TAW = $clog2(TABLE_SIZE);

	cfg_t           cfg_q;
	s1_t            s1;
	logic           acc, adv, out_free;
	logic [TAW-1:0] rom_addr;
	logic [7:0]     rom_data;
	logic           mem_we, mem_re;
	logic [BAW-1:0] mem_waddr, mem_raddr;
	logic [7:0]     mem_rdata;
	logic [7:0]     held_q;
	logic [7:0]     out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.play_mode      <= 1'b0;
			cfg_q.tone_period    <= TONE_PERIOD_RST;
			cfg_q.stream_period  <= STREAM_PERIOD_RST;
			cfg_q.output_channel <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PLAY_MODE:      cfg_q.play_mode      <= cfg_data[0];
				REG_TONE_PERIOD:    cfg_q.tone_period    <= cfg_data;
				REG_STREAM_PERIOD:  cfg_q.stream_period  <= cfg_data;
				REG_OUTPUT_CHANNEL: cfg_q.output_channel <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign adv      = s1.valid && out_free;
	assign s_tready = !s1.valid || out_free;
	assign acc      = s_tvalid && s_tready;

	dtsp_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.TABLE_SIZE   (TABLE_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.acc       (acc),
		.cmd       (s_tuser),
		.adv       (adv),
		.rom_addr  (rom_addr),
		.rom_data  (rom_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.s1        (s1)
	);

	dtsp_sine_rom #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_rom (
		.addr (rom_addr),
		.data (rom_data)
	);

	dtsp_sbuf #(
		.DEPTH (BUFFER_DEPTH)
	) u_sbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		case (s1.src)
			SRC_MEM:  out_value = mem_rdata;
			SRC_HELD: out_value = held_q;
			default:  out_value = s1.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			held_q   <= MIDPOINT;
		end else begin
			if (adv) begin
				m_tvalid <= 1'b1;
				if (s1.src == SRC_MEM) begin
					held_q <= mem_rdata;
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {6'd0, s1.total, s1.empty, s1.under, out_value};
			m_tuser <= s1.chan;
		end
	end

	a_under_implies_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[8] || m_tdata[9]))
		else $error("underrun result without empty buffer");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1.valid && m_tvalid && !m_tready))
		else $error("input stalled with a free stage");

	a_mem_read_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (!mem_we && s_tuser == CMD_TICK && cfg_q.play_mode))
		else $error("buffer read outside a stream tick");

	a_mem_data_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (s1.valid && s1.src == SRC_MEM))
		else $error("buffer read without a result waiting for it");

endmodule
`default_nettype wire

// ===== test/tb_dac_tone_and_stream_player.sv =====
`default_nettype none
module tb_dac_tone_and_stream_player;
	import dtsp_pkg::*;

	localparam logic [1:0]  CMD_RESERVED = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RANDOM_ITEMS = 180;

	typedef struct packed {
		logic [7:0]         value;
		logic               chan;
		logic               under;
		logic               empty;
		logic [TOTAL_W-1:0] total;
	} dac_result_t;

	class player_scoreboard;
		bit                mode;
		bit [PERIOD_W-1:0] tone_per;
		bit [PERIOD_W-1:0] stream_per;
		bit                chan;
		bit [7:0]          store [BUFFER_DEPTH_DEF];
		bit [9:0]          rd_pos;
		bit [9:0]          wr_pos;
		bit [7:0]          tbl_pos;
		bit [PERIOD_W-1:0] tick_cnt;
		bit [7:0]          held;
		bit [TOTAL_W-1:0]  under_cnt;
		bit                running;
		bit [7:0]          sine_rom [TABLE_SIZE_DEF];
		dac_result_t       expected_q [$];
		int unsigned       errors;

		function new();
			for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
				sine_rom[i] = sine_value(i);
			end
			mode       = 1'b0;
			tone_per   = TONE_PERIOD_RST;
			stream_per = STREAM_PERIOD_RST;
			chan       = 1'b0;
			rd_pos     = '0;
			wr_pos     = '0;
			tbl_pos    = '0;
			tick_cnt   = '0;
			held       = MIDPOINT;
			under_cnt  = '0;
			running    = 1'b0;
			errors     = 0;
		endfunction

		// sin(pi/2 * r / t) in Q30, truncating Taylor series
		function longint unsigned quarter_sin_q30(int unsigned r, int unsigned t);
			longint unsigned rr;
			longint unsigned tt;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned dv;
			longint          acc;
			rr = 64'(r);
			tt = 64'(t);
			if (r == 0) begin
				return 64'd0;
			end
			if (r >= t) begin
				return ONE_Q30;
			end
			x    = (HALF_PI_Q30 * rr) / tt;
			x2   = (x * x) >> 30;
			term = x;
			acc  = $signed(x);
			for (int n = 1; n <= 12; n++) begin
				dv   = 64'((2 * n) * (2 * n + 1));
				term = ((term * x2) >> 30) / dv;
				if (n % 2 == 1) begin
					acc = acc - $signed(term);
				end else begin
					acc = acc + $signed(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			if (acc > $signed(ONE_Q30)) begin
				acc = $signed(ONE_Q30);
			end
			return $unsigned(acc);
		endfunction

		function bit [7:0] sine_value(int unsigned i);
			int unsigned     q;
			int unsigned     quad;
			int unsigned     r;
			int unsigned     f;
			longint unsigned s;
			longint unsigned v;
			q    = 4 * i;
			quad = q / TABLE_SIZE_DEF;
			r    = q % TABLE_SIZE_DEF;
			f    = quad[0] ? TABLE_SIZE_DEF - r : r;
			s    = quarter_sin_q30(f, TABLE_SIZE_DEF);
			if (quad < 2) begin
				v = (64'd255 * ONE_Q30 + 64'd255 * s) >> 31;
			end else begin
				v = (64'd255 * ONE_Q30 - 64'd255 * s) >> 31;
			end
			return v[7:0];
		endfunction

		function void set_reg(reg_idx_t idx, logic [PERIOD_W-1:0] val);
			case (idx)
				REG_PLAY_MODE: mode = val[0];
				REG_TONE_PERIOD: tone_per = val;
				REG_STREAM_PERIOD: stream_per = val;
				REG_OUTPUT_CHANNEL: chan = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_transaction(logic [1:0] cmd, logic [7:0] smp);
			dac_result_t       r;
			bit [PERIOD_W-1:0] per;
			bit                emit;
			r    = '0;
			emit = 1'b0;
			case (cmd)
				CMD_START: begin
					rd_pos   = '0;
					wr_pos   = '0;
					tbl_pos  = '0;
					tick_cnt = '0;
					running  = 1'b1;
					r.value  = MIDPOINT;
					r.empty  = mode;
					emit     = 1'b1;
				end
				CMD_PUSH: begin
					if (running && mode) begin
						store[wr_pos] = smp;
						wr_pos++;
					end
				end
				CMD_TICK: begin
					if (running) begin
						per = mode ? stream_per : tone_per;
						if (per == 0) begin
							per = 20'd1;
						end
						tick_cnt++;
						if (tick_cnt >= per) begin
							tick_cnt = '0;
							emit     = 1'b1;
							if (!mode) begin
								r.value = sine_rom[tbl_pos];
								tbl_pos++;
							end else begin
								if (rd_pos != wr_pos) begin
									held = store[rd_pos];
									rd_pos++;
								end else begin
									r.under = 1'b1;
									under_cnt++;
								end
								r.value = held;
								r.empty = (rd_pos == wr_pos);
							end
						end
					end
				end
				default: ;
			endcase
			if (emit) begin
				r.chan  = chan;
				r.total = under_cnt;
				expected_q.push_back(r);
			end
		endfunction

		function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_output(logic [47:0] data, logic [0:0] user);
			dac_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected transaction: expected none actual data %h chan %h",
					$time, data, user);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp_field("dac_value", 32'(e.value), 32'(data[7:0]));
			cmp_field("underrun", 32'(e.under), 32'(data[8]));
			cmp_field("buffer_empty", 32'(e.empty), 32'(data[9]));
			cmp_field("underrun_total", e.total, data[41:10]);
			cmp_field("tdata pad", 32'd0, 32'(data[47:42]));
			cmp_field("dac_channel", 32'(e.chan), 32'(user[0]));
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data  = '0;

	player_scoreboard sb;
	int unsigned      burst_left   = 0;
	int unsigned      random_count = 0;
	int unsigned      cycle_count  = 0;
	int unsigned      hold_reqs    = 0;
	int unsigned      hold_seen    = 0;
	int unsigned      hold_left    = 0;
	int unsigned      rx_cycle     = 0;
	int unsigned      rx_style     = 0;

	dac_tone_and_stream_player i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: stall style re-chosen at random, plus long hold-offs on request
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 50 == 0) begin
			rx_style <= $urandom_range(0, 3);
		end
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			case (rx_style)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= rx_cycle[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_output(m_tdata, m_tuser);
		end
	end

	task automatic send_item(logic [1:0] cmd, logic [7:0] smp);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(40, 120);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap        = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		sb.note_transaction(cmd, smp);
	endtask

	task automatic ticks(int unsigned n);
		repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic pushes(int unsigned n);
		repeat (n) send_item(CMD_PUSH, 8'($urandom_range(0, 255)));
	endtask

	// items without a result may still be in flight: allow the pipeline to drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [19:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic write_config(bit md, bit [19:0] tp, bit [19:0] sp, bit ch);
		wait_idle();
		write_reg(REG_PLAY_MODE, {19'd0, md});
		write_reg(REG_TONE_PERIOD, tp);
		write_reg(REG_STREAM_PERIOD, sp);
		write_reg(REG_OUTPUT_CHANNEL, {19'd0, ch});
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase();
		int unsigned kind;
		int unsigned n;
		int unsigned k;
		int unsigned done;
		bit          md;
		bit [19:0]   per;
		kind = $urandom_range(0, 9);
		done = 0;
		if (kind <= 4) begin
			per = 20'($urandom_range(0, 4));
			write_config(1'b1, 20'($urandom_range(0, 20'hFFFFF)), per,
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) != 0) begin
				send_item(CMD_START, 8'($urandom_range(0, 255)));
				done++;
			end
			n = $urandom_range(20, 60);
			while (done < n) begin
				k = $urandom_range(1, 12);
				pushes(k);
				done += k;
				k = $urandom_range(1, 12) * ((per == 0) ? 32'd1 : 32'(per));
				ticks(k);
				done += k;
				if ($urandom_range(0, 19) == 0) begin
					send_item(CMD_RESERVED, 8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 29) == 0) begin
					send_item(CMD_START, 8'($urandom_range(0, 255)));
					done++;
				end
			end
		end else if (kind <= 7) begin
			per = 20'($urandom_range(0, 6));
			write_config(1'b0, per, 20'($urandom_range(0, 20'hFFFFF)),
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) != 0) begin
				send_item(CMD_START, 8'($urandom_range(0, 255)));
				done++;
			end
			n = $urandom_range(20, 60);
			while (done < n) begin
				if ($urandom_range(0, 19) == 0) begin
					if ($urandom_range(0, 1) != 0) begin
						send_item(CMD_PUSH, 8'($urandom_range(0, 255)));
					end else begin
						send_item(CMD_RESERVED, 8'($urandom_range(0, 255)));
					end
				end
				send_item(CMD_TICK, 8'($urandom_range(0, 255)));
				done++;
			end
		end else if (kind == 8) begin
			// count runs up under a long period, then the period drops below it
			md = 1'($urandom_range(0, 1));
			per = ($urandom_range(0, 1) != 0) ? 20'hFFFFF :
				20'($urandom_range(1000, 20'hFFFFE));
			write_config(md, per, per, 1'($urandom_range(0, 1)));
			send_item(CMD_START, 8'($urandom_range(0, 255)));
			k = $urandom_range(3, 30);
			ticks(k);
			if (md) begin
				pushes(3);
			end
			per = 20'($urandom_range(0, k - 1));
			write_config(md, per, per, 1'($urandom_range(0, 1)));
			ticks(10);
			done = k + 14;
		end else begin
			md = 1'($urandom_range(0, 1));
			write_config(md, 20'd1, 20'd1, 1'($urandom_range(0, 1)));
			send_item(CMD_START, 8'($urandom_range(0, 255)));
			repeat (40) begin
				if ($urandom_range(0, 1) != 0) begin
					send_item(CMD_PUSH, 8'($urandom_range(0, 255)));
				end else begin
					send_item(CMD_TICK, 8'($urandom_range(0, 255)));
				end
			end
			done = 41;
		end
		random_count += done;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any start nothing is emitted
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'hFF);
		send_item(CMD_PUSH, 8'hFF);
		send_item(CMD_RESERVED, 8'h00);
		write_config(1'b1, TONE_PERIOD_RST, 20'd2, 1'b1);
		send_item(CMD_PUSH, 8'h11);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_START, 8'h00);
		ticks(2);
		send_item(CMD_PUSH, 8'h00);
		send_item(CMD_PUSH, 8'hFF);
		ticks(4);
		ticks(2);
		// zero period acts as one; push ignored in tone mode
		write_config(1'b0, 20'd0, 20'd3, 1'b0);
		send_item(CMD_START, 8'hFF);
		ticks(2);
		send_item(CMD_PUSH, 8'hAA);
		send_item(CMD_RESERVED, 8'h55);

		// long receiver hold-off while every tick emits
		write_config(1'b0, 20'd1, 20'd1, 1'b1);
		send_item(CMD_START, 8'h00);
		hold_reqs <= hold_reqs + 1;
		ticks(80);

		// a full ring of pushes makes the buffer look empty
		write_config(1'b1, 20'($urandom_range(1, 8)), 20'd1, 1'($urandom_range(0, 1)));
		send_item(CMD_START, 8'h00);
		pushes(BUFFER_DEPTH_DEF);
		ticks(2);
		pushes(3);
		ticks(5);

		while (random_count < RANDOM_ITEMS) begin
			random_phase();
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/dtsp_pkg.sv
rtl/dtsp_sbuf.sv
rtl/dtsp_sine_rom.sv
rtl/dtsp_ctrl.sv
rtl/dac_tone_and_stream_player.sv
test/tb_dac_tone_and_stream_player.sv
